[hdl/scaq_pkg.sv]
// Shared types, constants and translation tables for the scancode to ASCII queue unit.
package scaq_pkg;

    localparam int QUEUE_DEPTH_DEF = 256;
    localparam int CHAR_W          = 7;
    localparam int CODE_W          = 8;
    localparam int FILL_W          = 8;
    localparam int LED_W           = 3;
    localparam int TAB_SPACES      = 4;
    localparam int TAB_CNT_W       = $clog2(TAB_SPACES);
    localparam int CQ_DEPTH        = 4;
    localparam int CQ_AW           = $clog2(CQ_DEPTH);

    localparam logic [CODE_W-1:0] SC_RELEASE = 8'h80;
    localparam logic [CODE_W-1:0] SC_LSHIFT  = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT  = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BRK = SC_LSHIFT | SC_RELEASE;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BRK = SC_RSHIFT | SC_RELEASE;
    localparam logic [CODE_W-1:0] SC_CAPS    = 8'h3A;
    localparam logic [CODE_W-1:0] SC_TAB     = 8'h0F;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
    localparam logic [LED_W-1:0]  LED_CAPS   = 3'b100;
    localparam logic [LED_W-1:0]  LED_OFF    = 3'b000;

    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_PUSH,
        OP_TAB,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] chr;
        logic              led_upd;
        logic [LED_W-1:0]  led_mask;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_TAB,
        BK_FIN,
        BK_READ
    } t_back_state;

    // Unshifted set-1 table; codes without a character give zero.
    function automatic logic [CHAR_W-1:0] plain_char(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        unique case (code)
            7'h01: c = 7'h1B;
            7'h02: c = 7'h31;  7'h03: c = 7'h32;  7'h04: c = 7'h33;  7'h05: c = 7'h34;
            7'h06: c = 7'h35;  7'h07: c = 7'h36;  7'h08: c = 7'h37;  7'h09: c = 7'h38;
            7'h0A: c = 7'h39;  7'h0B: c = 7'h30;  7'h0C: c = 7'h2D;  7'h0D: c = 7'h3D;
            7'h0E: c = 7'h08;  7'h0F: c = 7'h09;
            7'h10: c = 7'h71;  7'h11: c = 7'h77;  7'h12: c = 7'h65;  7'h13: c = 7'h72;
            7'h14: c = 7'h74;  7'h15: c = 7'h79;  7'h16: c = 7'h75;  7'h17: c = 7'h69;
            7'h18: c = 7'h6F;  7'h19: c = 7'h70;  7'h1A: c = 7'h5B;  7'h1B: c = 7'h5D;
            7'h1C: c = 7'h0A;
            7'h1E: c = 7'h61;  7'h1F: c = 7'h73;  7'h20: c = 7'h64;  7'h21: c = 7'h66;
            7'h22: c = 7'h67;  7'h23: c = 7'h68;  7'h24: c = 7'h6A;  7'h25: c = 7'h6B;
            7'h26: c = 7'h6C;  7'h27: c = 7'h3B;  7'h28: c = 7'h27;  7'h29: c = 7'h60;
            7'h2B: c = 7'h5C;  7'h2C: c = 7'h7A;  7'h2D: c = 7'h78;  7'h2E: c = 7'h63;
            7'h2F: c = 7'h76;  7'h30: c = 7'h62;  7'h31: c = 7'h6E;  7'h32: c = 7'h6D;
            7'h33: c = 7'h2C;  7'h34: c = 7'h2E;  7'h35: c = 7'h2F;  7'h37: c = 7'h2A;
            7'h39: c = 7'h20;
            7'h47: c = 7'h37;  7'h48: c = 7'h38;  7'h49: c = 7'h39;  7'h4A: c = 7'h2D;
            7'h4B: c = 7'h34;  7'h4C: c = 7'h35;  7'h4D: c = 7'h36;  7'h4E: c = 7'h2B;
            7'h4F: c = 7'h31;  7'h50: c = 7'h32;  7'h51: c = 7'h33;  7'h52: c = 7'h30;
            7'h53: c = 7'h2E;
            default: c = CHAR_NONE;
        endcase
        return c;
    endfunction

    // Shifted table: letters move to upper case, the symbol keys have their own entries.
    function automatic logic [CHAR_W-1:0] shifted_char(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] p;
        logic [CHAR_W-1:0] c;
        p = plain_char(code);
        unique case (code)
            7'h02: c = 7'h21;  7'h03: c = 7'h40;  7'h04: c = 7'h23;  7'h05: c = 7'h24;
            7'h06: c = 7'h25;  7'h07: c = 7'h5E;  7'h08: c = 7'h26;  7'h09: c = 7'h2A;
            7'h0A: c = 7'h28;  7'h0B: c = 7'h29;  7'h0C: c = 7'h5F;  7'h0D: c = 7'h2B;
            7'h1A: c = 7'h7B;  7'h1B: c = 7'h7D;  7'h27: c = 7'h3A;  7'h28: c = 7'h22;
            7'h29: c = 7'h7E;  7'h2B: c = 7'h7C;  7'h33: c = 7'h3C;  7'h34: c = 7'h3E;
            7'h35: c = 7'h3F;
            default: begin
                if (p >= 7'h61 && p <= 7'h7A) begin
                    c = p - 7'h20;
                end else begin
                    c = p;
                end
            end
        endcase
        return c;
    endfunction

endpackage

[hdl/scaq_front.sv]
// Front end: accepts items, tracks shift and caps, and turns each item into a command.
module scaq_front
    import scaq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic r_shift;
    logic r_caps;
    logic n_shift;
    logic n_caps;
    logic accept;
    logic [CHAR_W-1:0] chr;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    always_comb begin
        n_shift = r_shift;
        n_caps  = r_caps;
        chr     = (r_shift || r_caps) ? shifted_char(i_code[CHAR_W-1:0])
                                      : plain_char(i_code[CHAR_W-1:0]);
        o_cmd.op      = OP_NONE;
        o_cmd.chr     = chr;
        o_cmd.led_upd = 1'b0;
        if (i_kind == KIND_READ) begin
            o_cmd.op = OP_READ;
        end else if (i_code == SC_LSHIFT || i_code == SC_RSHIFT) begin
            n_shift = 1'b1;
        end else if (i_code == SC_LSHIFT_BRK || i_code == SC_RSHIFT_BRK) begin
            n_shift = 1'b0;
        end else if (i_code == SC_CAPS) begin
            n_caps        = !r_caps;
            o_cmd.led_upd = 1'b1;
        end else if (i_code == SC_TAB) begin
            o_cmd.op = OP_TAB;
        end else if (!i_code[CODE_W-1] && chr != CHAR_NONE) begin
            o_cmd.op = OP_PUSH;
        end
        o_cmd.led_mask = n_caps ? LED_CAPS : LED_OFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
        end else if (accept) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
        end
    end

endmodule

[hdl/scaq_cmd_queue.sv]
// Short command queue that decouples the front end from the back end.
module scaq_cmd_queue
    import scaq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd             r_slot [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wr;
    logic [CQ_AW-1:0] r_rd;
    logic [CQ_AW:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (CQ_AW+1)'(CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hdl/scaq_back.sv]
// Back end: character memory, queue indexes and the registered result.
module scaq_back
    import scaq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [CHAR_W-1:0] o_read_char,
    output logic              o_led_upd,
    output logic [LED_W-1:0]  o_led_mask,
    output logic [FILL_W-1:0] o_fill
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    logic [CHAR_W-1:0] r_mem [QUEUE_DEPTH];
    logic [CHAR_W-1:0] r_rd_data;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [AW-1:0]        r_wr_idx;
    logic [AW-1:0]        n_wr_idx;
    logic [AW-1:0]        r_rd_idx;
    logic [AW-1:0]        n_rd_idx;
    logic [AW-1:0]        r_count;
    logic [AW-1:0]        n_count;
    logic [TAB_CNT_W-1:0] r_tab_left;
    logic [TAB_CNT_W-1:0] n_tab_left;
    logic [LED_W-1:0]     r_hold_mask;
    logic [LED_W-1:0]     n_hold_mask;
    logic                 r_hit;
    logic                 n_hit;

    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_upd;
    logic [LED_W-1:0]     r_out_mask;
    logic [FILL_W-1:0]    r_out_fill;

    logic                 out_free;
    logic                 load_out;
    logic [CHAR_W-1:0]    out_char;
    logic                 out_upd;
    logic [LED_W-1:0]     out_mask;
    logic                 wr_en;
    logic [CHAR_W-1:0]    wr_data;
    logic                 rd_en;
    logic                 push_ok;

    assign out_free = !r_out_valid || i_ready;
    assign push_ok  = (r_count != LAST_IDX);

    always_comb begin
        n_state     = r_state;
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_count     = r_count;
        n_tab_left  = r_tab_left;
        n_hold_mask = r_hold_mask;
        n_hit       = r_hit;
        o_cmd_pop   = 1'b0;
        load_out    = 1'b0;
        out_char    = CHAR_NONE;
        out_upd     = 1'b0;
        out_mask    = r_hold_mask;
        wr_en       = 1'b0;
        wr_data     = CHAR_SPACE;
        rd_en       = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_hold_mask = i_cmd.led_mask;
                    case (i_cmd.op)
                        OP_READ: begin
                            o_cmd_pop = 1'b1;
                            n_hit     = (r_count != '0);
                            if (r_count != '0) begin
                                rd_en    = 1'b1;
                                n_rd_idx = (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
                                n_count  = r_count - 1'b1;
                            end
                            n_state = BK_READ;
                        end
                        OP_TAB: begin
                            o_cmd_pop  = 1'b1;
                            wr_en      = push_ok;
                            n_tab_left = TAB_CNT_W'(TAB_SPACES - 1);
                            n_state    = BK_TAB;
                        end
                        default: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                load_out  = 1'b1;
                                out_upd   = i_cmd.led_upd;
                                out_mask  = i_cmd.led_mask;
                                wr_en     = (i_cmd.op == OP_PUSH) && push_ok;
                                wr_data   = i_cmd.chr;
                            end
                        end
                    endcase
                end
            end
            BK_TAB: begin
                wr_en      = push_ok;
                n_tab_left = r_tab_left - 1'b1;
                if (r_tab_left == TAB_CNT_W'(1)) begin
                    n_state = BK_FIN;
                end
            end
            BK_FIN: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            BK_READ: begin
                if (out_free) begin
                    load_out = 1'b1;
                    out_char = r_hit ? r_rd_data : CHAR_NONE;
                    n_state  = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
        if (wr_en) begin
            n_wr_idx = (r_wr_idx == LAST_IDX) ? '0 : r_wr_idx + 1'b1;
            n_count  = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_count     <= '0;
            r_tab_left  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_idx   <= n_wr_idx;
            r_rd_idx   <= n_rd_idx;
            r_count    <= n_count;
            r_tab_left <= n_tab_left;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_mask <= n_hold_mask;
        r_hit       <= n_hit;
        if (load_out) begin
            r_out_char <= out_char;
            r_out_upd  <= out_upd;
            r_out_mask <= out_mask;
            r_out_fill <= FILL_W'(n_count);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_char = r_out_char;
    assign o_led_upd   = r_out_upd;
    assign o_led_mask  = r_out_mask;
    assign o_fill      = r_out_fill;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> r_count != LAST_IDX)
        else $error("character pushed into a full queue");

    a_no_read_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> r_count != '0)
        else $error("character popped from an empty queue");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> r_count == $past(r_count) + 1'b1)
        else $error("held count did not follow a push");

    a_read_after_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_IDLE && n_state == BK_READ) |-> o_cmd_pop)
        else $error("read started without taking a command");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (r_state != BK_TAB))
        else $error("result produced while tab spaces are still being written");

endmodule

[hdl/scancode_to_ascii_queue_unit.sv]
// Top level of the set-1 scancode to ASCII translator with its character queue.
// An accepted item is registered in the command queue, taken from it by the back end
// and held in the output register; a read also passes BK_READ, a tab BK_TAB and BK_FIN.
// Throughput: one plain scancode item per cycle while the result port is not stalled;
// a read holds the back end in BK_READ and a tab in BK_TAB and BK_FIN before the next command.
// Reset (synchronous, active low) empties the queue and clears shift and caps at once.
module scancode_to_ascii_queue_unit
    import scaq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] scancode
    input  logic        i_s_axis_tuser,  // [0] kind: 0 scancode, 1 read request
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // [6:0] read_char, [9:7] led_mask,
                                         // [17:10] fill_level, [23:18] zero
    output logic        o_m_axis_tuser   // [0] led_update
);

    // The front end decodes each accepted item against its own shift and caps
    // state, so the LED mask seen in every result is settled in item order there.
    logic q_full;
    logic f_push;
    t_cmd f_cmd;
    logic q_valid;
    t_cmd q_head;
    logic b_pop;

    logic [CHAR_W-1:0] read_char;
    logic              led_upd;
    logic [LED_W-1:0]  led_mask;
    logic [FILL_W-1:0] fill;

    scaq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_kind   (i_s_axis_tuser),
        .i_code   (i_s_axis_tdata),
        .i_q_full (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (f_push),
        .o_cmd    (f_cmd)
    );

    // A few commands of slack let the front end keep taking items while the back
    // end is busy writing tab spaces or waiting on a stalled result port.
    scaq_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .i_pop   (b_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // The back end owns the character memory and the fill count, and holds
    // each result in an output register until it is taken.
    scaq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_head),
        .o_cmd_pop   (b_pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_read_char (read_char),
        .o_led_upd   (led_upd),
        .o_led_mask  (led_mask),
        .o_fill      (fill)
    );

    assign o_m_axis_tdata = {6'b0, fill, led_mask, read_char};
    assign o_m_axis_tuser = led_upd;

endmodule
